// File: sv/cla_pkg.sv
// Shared types and constants for the contact logic array evaluator.
// Holds the beat payload structs, control state encoding and opcode codes.
// No dependencies; imported by every module of the block.
package cla_pkg;

    localparam int WORD_W    = 64;
    localparam int LANE_W    = 2 * WORD_W;   // one word of mask and one of result
    localparam int COUNT_W   = 9;
    localparam int BIT_POS_W = 6;            // bit position within a status word

    // opcodes of the input beat
    localparam logic [2:0] OP_WRITE_CIRCUIT = 3'd0;
    localparam logic [2:0] OP_SET_BIT       = 3'd1;
    localparam logic [2:0] OP_CLEAR_BIT     = 3'd2;
    localparam logic [2:0] OP_CORRECT_WORD  = 3'd3;
    localparam logic [2:0] OP_RECALCULATE   = 3'd4;

    // table select codes
    localparam logic TBL_PREPARE = 1'b0;
    localparam logic TBL_MAIN    = 1'b1;

    // configuration register indexes
    localparam logic [0:0] CFG_PREPARE_COUNT = 1'b0;
    localparam logic [0:0] CFG_MAIN_COUNT    = 1'b1;

    typedef struct packed {
        logic [2:0]        opcode;
        logic              table_select;
        logic [7:0]        entry_index;
        logic [1:0]        word_select;
        logic [7:0]        bit_index;
        logic [WORD_W-1:0] first_word;
        logic [WORD_W-1:0] second_word;
    } cla_in_t;

    typedef struct packed {
        logic [WORD_W-1:0] result_word;
        logic [1:0]        word_number;
        logic              last_word;
        logic              was_pending;
    } cla_out_t;

    // control from the sequencer to the match unit
    typedef struct packed {
        logic clear;
        logic hit_en;
    } cla_match_ctrl_t;

    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_PREP,
        ST_FOLD,
        ST_MAIN,
        ST_EMIT
    } cla_state_t;

endpackage

// File: sv/cla_circuit_ram.sv
// Circuit table storage: one row per circuit, one lane per status word.
// Each lane holds a mask word and a result word, and has its own write enable.
// Depends on cla_pkg for the lane width.
module cla_circuit_ram #(
    parameter int LANES = 4,
    parameter int DEPTH = 512,
    parameter int AW    = 9
) (
    input  logic                                 aclk,
    input  logic [LANES-1:0]                     we,
    input  logic [AW-1:0]                        waddr,
    input  logic [cla_pkg::LANE_W-1:0]           wdata,
    input  logic                                 re,
    input  logic [AW-1:0]                        raddr,
    output logic [LANES-1:0][cla_pkg::LANE_W-1:0] rdata
);
    import cla_pkg::*;

    logic [LANES-1:0][LANE_W-1:0] mem [DEPTH];
    logic [LANES-1:0][LANE_W-1:0] rdata_reg;

    // lane-enabled write
    always_ff @(posedge aclk) begin
        for (int l = 0; l < LANES; l++) begin
            if (we[l]) begin
                mem[waddr][l] <= wdata;
            end
        end
    end

    // registered row read
    always_ff @(posedge aclk) begin
        if (re) begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

// File: sv/cla_match_unit.sv
// Shared match unit: tests one circuit row against a vector and accumulates.
// A circuit fires when its mask is a subset of the vector; results are ORed.
// Depends on cla_pkg for widths and the control struct.
module cla_match_unit #(
    parameter int LANES = 4
) (
    input  logic                                  aclk,
    input  cla_pkg::cla_match_ctrl_t              ctrl,
    input  logic [LANES-1:0][cla_pkg::WORD_W-1:0] vec,
    input  logic [LANES-1:0][cla_pkg::LANE_W-1:0] row,
    output logic [LANES-1:0][cla_pkg::WORD_W-1:0] acc
);
    import cla_pkg::*;

    logic [LANES-1:0][WORD_W-1:0] acc_reg;
    logic [LANES-1:0][WORD_W-1:0] acc_next;
    logic [LANES-1:0]             lane_ok;
    logic                         hit;

    // subset test per lane, then across lanes
    always_comb begin
        for (int l = 0; l < LANES; l++) begin
            lane_ok[l] = ((row[l][LANE_W-1:WORD_W] & ~vec[l]) == '0);
        end
        hit = &lane_ok;
    end

    // accumulate results of firing circuits
    always_comb begin
        acc_next = acc_reg;
        if (ctrl.clear) begin
            acc_next = '0;
        end else if (ctrl.hit_en && hit) begin
            for (int l = 0; l < LANES; l++) begin
                acc_next[l] = acc_reg[l] | row[l][WORD_W-1:0];
            end
        end
    end

    always_ff @(posedge aclk) begin
        acc_reg <= acc_next;
    end

    assign acc = acc_reg;

endmodule

// File: sv/contact_logic_array_evaluator.sv
// Contact logic array evaluator: top level with sequencer, status and output stage.
// Instantiates cla_circuit_ram and cla_match_unit; uses cla_pkg types.
// s_valid/s_ready/s_data carry one command beat (circuit word write, set or clear
//   of a status bit, status word correction, recalculate). m_valid/m_ready/m_data
//   carry result beats; only recalculate produces them, one beat per status word,
//   word 0 first, last_word set on the final one.
// cfg_we/cfg_index/cfg_wdata write the prepare table count (0) and the main table
//   count (1); write them only while no command is in flight.
// For every command but recalculate the sequencer stays idle and s_ready stays high.
//   Recalculate reads one circuit row per cycle through the single table read
//   port, first the P prepare rows and then the M main rows (P, M the clamped
//   counts), and s_ready stays low until the last result beat has been loaded.
// Reset: aresetn low clears status, counts and the pending flag; after it a
//   clearing pass over all 2 * MAX_CIRCUITS rows (512 by default) zeroes both
//   tables, with s_ready low. Configuration writes are taken throughout.
// Stall: the result register holds its beat while m_ready is low and the
//   sequencer waits in the emit state, with s_ready low, before loading the
//   next word, so that a stall lengthens the recalculate.
module contact_logic_array_evaluator #(
    parameter int MAX_CIRCUITS = 256,
    parameter int STATUS_WORDS = 4
) (
    input  logic                       aclk,
    input  logic                       aresetn,
    input  logic                       s_valid,
    output logic                       s_ready,
    input  cla_pkg::cla_in_t           s_data,
    output logic                       m_valid,
    input  logic                       m_ready,
    output cla_pkg::cla_out_t          m_data,
    input  logic                       cfg_we,
    input  logic [0:0]                 cfg_index,
    input  logic [cla_pkg::COUNT_W-1:0] cfg_wdata
);
    import cla_pkg::*;

    localparam int RAM_DEPTH = 2 * MAX_CIRCUITS;
    localparam int RAM_AW    = $clog2(RAM_DEPTH);
    localparam int CW        = $clog2(MAX_CIRCUITS + 1);
    localparam int SW_AW     = (STATUS_WORDS > 1) ? $clog2(STATUS_WORDS) : 1;

    cla_state_t st_reg, st_next;

    logic [CW-1:0]                       idx_reg, idx_next;
    logic [SW_AW-1:0]                    wcnt_reg, wcnt_next;
    logic [RAM_AW-1:0]                   clr_reg, clr_next;
    logic                                rd_en_reg, rd_en_next;
    logic                                pend_reg, pend_next;
    logic                                was_pend_reg, was_pend_next;
    logic [COUNT_W-1:0]                  prep_count_reg, main_cnt_reg;
    logic [STATUS_WORDS-1:0][WORD_W-1:0] status_reg, status_next;
    logic [STATUS_WORDS-1:0][WORD_W-1:0] work_reg, work_next;
    logic                                m_valid_reg, m_valid_next;
    cla_out_t                            m_data_reg, m_data_next;

    logic [STATUS_WORDS-1:0]              ram_we;
    logic [RAM_AW-1:0]                    ram_waddr;
    logic [LANE_W-1:0]                    ram_wdata;
    logic [RAM_AW-1:0]                    ram_raddr;
    logic [STATUS_WORDS-1:0][LANE_W-1:0]  ram_rdata;
    cla_match_ctrl_t                      mctrl;
    logic [STATUS_WORDS-1:0][WORD_W-1:0]  match_vec;
    logic [STATUS_WORDS-1:0][WORD_W-1:0]  acc;

    logic [CW-1:0]          pcnt, mcnt, wr_cnt;
    logic                   wr_ok;
    logic [1:0]             stat_word;
    logic                   stat_ok;
    logic [SW_AW-1:0]       stat_idx;
    logic [WORD_W-1:0]      stat_old, stat_new;

    // count register clamped to table capacity
    function automatic logic [CW-1:0] clamp_count(input logic [COUNT_W-1:0] c);
        logic [31:0] ext;
        ext = 32'(c);
        if (ext > 32'(MAX_CIRCUITS)) begin
            ext = 32'(MAX_CIRCUITS);
        end
        return CW'(ext);
    endfunction

    // table row address: main table sits above the prepare table
    function automatic logic [RAM_AW-1:0] row_addr(input logic tbl, input logic [31:0] e);
        return RAM_AW'((tbl ? 32'(MAX_CIRCUITS) : 32'd0) + e);
    endfunction

    assign pcnt = clamp_count(prep_count_reg);
    assign mcnt = clamp_count(main_cnt_reg);

    // circuit write bound check
    assign wr_cnt = (s_data.table_select == TBL_MAIN) ? mcnt : pcnt;
    assign wr_ok  = (32'(s_data.entry_index) < 32'(wr_cnt)) &&
                    (32'(s_data.word_select) < 32'(STATUS_WORDS));

    // status word addressed by bit index or by correction word select
    always_comb begin
        stat_word = (s_data.opcode == OP_CORRECT_WORD) ? s_data.word_select
                                                        : s_data.bit_index[7:6];
        stat_ok   = (32'(stat_word) < 32'(STATUS_WORDS));
        stat_idx  = SW_AW'(stat_word);
        stat_old  = status_reg[stat_idx];
        priority case (s_data.opcode)
            OP_SET_BIT:
                stat_new = stat_old | (64'd1 << s_data.bit_index[BIT_POS_W-1:0]);
            OP_CLEAR_BIT:
                stat_new = stat_old & ~(64'd1 << s_data.bit_index[BIT_POS_W-1:0]);
            default:
                stat_new = s_data.first_word | (stat_old & s_data.second_word);
        endcase
    end

    // sequencer: next state and datapath control
    always_comb begin
        st_next       = st_reg;
        idx_next      = idx_reg;
        wcnt_next     = wcnt_reg;
        clr_next      = clr_reg;
        rd_en_next    = 1'b0;
        pend_next     = pend_reg;
        was_pend_next = was_pend_reg;
        status_next   = status_reg;
        work_next     = work_reg;
        m_valid_next  = m_valid_reg;
        m_data_next   = m_data_reg;
        ram_we        = '0;
        ram_waddr     = clr_reg;
        ram_wdata     = '0;
        ram_raddr     = '0;
        mctrl.clear   = 1'b0;
        mctrl.hit_en  = rd_en_reg;
        s_ready       = 1'b0;

        if (m_valid_reg && m_ready) begin
            m_valid_next = 1'b0;
        end

        unique case (st_reg)
            ST_CLEAR: begin
                ram_we = '1;
                if (clr_reg == RAM_AW'(RAM_DEPTH - 1)) begin
                    st_next = ST_IDLE;
                end else begin
                    clr_next = clr_reg + RAM_AW'(1);
                end
            end
            ST_IDLE: begin
                s_ready = 1'b1;
                if (s_valid) begin
                    unique case (s_data.opcode)
                        OP_WRITE_CIRCUIT: begin
                            if (wr_ok) begin
                                ram_we[SW_AW'(s_data.word_select)] = 1'b1;
                                ram_waddr = row_addr(s_data.table_select,
                                                     32'(s_data.entry_index));
                                ram_wdata = {s_data.first_word, s_data.second_word};
                            end
                        end
                        OP_SET_BIT, OP_CLEAR_BIT, OP_CORRECT_WORD: begin
                            if (stat_ok) begin
                                status_next[stat_idx] = stat_new;
                                if (stat_new != stat_old) begin
                                    pend_next = 1'b1;
                                end
                            end
                        end
                        OP_RECALCULATE: begin
                            was_pend_next = pend_reg;
                            pend_next     = 1'b0;
                            mctrl.clear   = 1'b1;
                            idx_next      = '0;
                            st_next       = ST_PREP;
                        end
                        default: ;
                    endcase
                end
            end
            ST_PREP: begin
                if (idx_reg < pcnt) begin
                    ram_raddr  = row_addr(TBL_PREPARE, 32'(idx_reg));
                    rd_en_next = 1'b1;
                    idx_next   = idx_reg + CW'(1);
                end else begin
                    st_next = ST_FOLD;
                end
            end
            ST_FOLD: begin
                work_next   = status_reg | acc;
                mctrl.clear = 1'b1;
                idx_next    = '0;
                st_next     = ST_MAIN;
            end
            ST_MAIN: begin
                if (idx_reg < mcnt) begin
                    ram_raddr  = row_addr(TBL_MAIN, 32'(idx_reg));
                    rd_en_next = 1'b1;
                    idx_next   = idx_reg + CW'(1);
                end else begin
                    wcnt_next = '0;
                    st_next   = ST_EMIT;
                end
            end
            ST_EMIT: begin
                if (!m_valid_reg || m_ready) begin
                    m_valid_next            = 1'b1;
                    m_data_next.result_word = acc[wcnt_reg];
                    m_data_next.word_number = 2'(wcnt_reg);
                    m_data_next.last_word   = (32'(wcnt_reg) == 32'(STATUS_WORDS - 1));
                    m_data_next.was_pending = was_pend_reg;
                    if (32'(wcnt_reg) == 32'(STATUS_WORDS - 1)) begin
                        st_next = ST_IDLE;
                    end else begin
                        wcnt_next = wcnt_reg + SW_AW'(1);
                    end
                end
            end
            default: st_next = ST_IDLE;
        endcase
    end

    // prepare pass tests the status, main pass the working copy
    assign match_vec = (st_reg == ST_MAIN) ? work_reg : status_reg;

    // control state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            st_reg      <= ST_CLEAR;
            clr_reg     <= '0;
            idx_reg     <= '0;
            wcnt_reg    <= '0;
            rd_en_reg   <= 1'b0;
            pend_reg    <= 1'b0;
            status_reg  <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            st_reg      <= st_next;
            clr_reg     <= clr_next;
            idx_reg     <= idx_next;
            wcnt_reg    <= wcnt_next;
            rd_en_reg   <= rd_en_next;
            pend_reg    <= pend_next;
            status_reg  <= status_next;
            m_valid_reg <= m_valid_next;
        end
    end

    // configuration registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            prep_count_reg <= '0;
            main_cnt_reg   <= '0;
        end else if (cfg_we) begin
            unique case (cfg_index)
                CFG_PREPARE_COUNT: prep_count_reg <= cfg_wdata;
                CFG_MAIN_COUNT:    main_cnt_reg   <= cfg_wdata;
                default: ;
            endcase
        end
    end

    // payload registers
    always_ff @(posedge aclk) begin
        was_pend_reg <= was_pend_next;
        work_reg     <= work_next;
        m_data_reg   <= m_data_next;
    end

    cla_circuit_ram #(
        .LANES (STATUS_WORDS),
        .DEPTH (RAM_DEPTH),
        .AW    (RAM_AW)
    ) u_ram (
        .aclk  (aclk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .re    (rd_en_next),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    cla_match_unit #(
        .LANES (STATUS_WORDS)
    ) u_match (
        .aclk (aclk),
        .ctrl (mctrl),
        .vec  (match_vec),
        .row  (ram_rdata),
        .acc  (acc)
    );

    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

endmodule

// File: sim/contact_logic_array_evaluator_test.sv
// Self-checking testbench for the contact logic array evaluator: a directed table, then
// random command phases over several table counts. Commands are predicted in the bench.
// Depends on cla_pkg and contact_logic_array_evaluator only.
`timescale 1ns / 1ps

module contact_logic_array_evaluator_test;
    import cla_pkg::*;

    localparam int IDLE_PCT       = 21;
    localparam int WATCHDOG_LIMIT = 4000;
    localparam int SETTLE_CYCLES  = 16;
    localparam int DRAIN_CYCLES   = 40;
    localparam int HOLD_CYCLES    = 300;
    localparam int PHASES         = 9;
    localparam int PHASE_ITEMS    = 36;
    localparam int STEADY_PHASE   = 2;
    localparam int STALL_PHASE    = 3;
    localparam int TABLE_DEPTH    = 256;

    // opcodes the block must ignore
    localparam logic [2:0] OP_RESERVED_5 = 3'd5;
    localparam logic [2:0] OP_RESERVED_6 = 3'd6;
    localparam logic [2:0] OP_RESERVED_7 = 3'd7;

    localparam logic [63:0] ALL_ONES = 64'hFFFF_FFFF_FFFF_FFFF;

    // table counts per random phase: zero, small, above capacity and full
    localparam int PHASE_PREP [PHASES] = '{0, 6, 16, 3, 511, 5, 256, 12, 0};
    localparam int PHASE_MAIN [PHASES] = '{4, 0, 16, 40, 256, 9, 511, 0, 0};

    typedef struct packed {
        cla_in_t      cmd;
        logic         typed;
        logic [255:0] typed_result;
        logic         typed_pending;
    } directed_row_t;

    logic                aclk;
    logic                aresetn;
    logic                s_valid;
    logic                s_ready;
    cla_in_t             s_data;
    logic                m_valid;
    logic                m_ready;
    cla_out_t            m_data;
    logic                cfg_we;
    logic [0:0]          cfg_index;
    logic [COUNT_W-1:0]  cfg_wdata;

    // predicted block state
    logic [255:0]        status_now;
    logic [255:0]        prep_mask_tbl [TABLE_DEPTH];
    logic [255:0]        prep_res_tbl  [TABLE_DEPTH];
    logic [255:0]        main_mask_tbl [TABLE_DEPTH];
    logic [255:0]        main_res_tbl  [TABLE_DEPTH];
    logic                recalc_flag;
    logic [COUNT_W-1:0]  prep_count_reg;
    logic [COUNT_W-1:0]  main_cnt_reg;

    cla_out_t            awaited_words [$];
    directed_row_t       directed_rows [$];
    int                  error_count;
    logic                steady_flow;
    logic                stall_request;

    contact_logic_array_evaluator u_top (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .s_data    (s_data),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_data    (m_data),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata)
    );

    initial begin
        aclk = 1'b0;
        forever #2 aclk = ~aclk;
    end

    // tables and status come up zero after reset and the clearing pass
    initial begin
        int e;
        status_now     = '0;
        recalc_flag    = 1'b0;
        prep_count_reg = '0;
        main_cnt_reg   = '0;
        error_count    = 0;
        steady_flow    = 1'b0;
        stall_request  = 1'b0;
        for (e = 0; e < TABLE_DEPTH; e++) begin
            prep_mask_tbl[e] = '0;
            prep_res_tbl[e]  = '0;
            main_mask_tbl[e] = '0;
            main_res_tbl[e]  = '0;
        end
    end

    function automatic int eff_count(input logic [COUNT_W-1:0] c);
        return (c > 9'd256) ? TABLE_DEPTH : int'(c);
    endfunction

    // applies one command to the predicted state; returns the number of result beats
    function automatic int predict_command(input cla_in_t cmd, output cla_out_t beats [4]);
        logic [255:0] prior;
        logic [255:0] work;
        logic [255:0] acc;
        int           e;
        int           w;
        int           n;
        n     = 0;
        prior = status_now;
        acc   = '0;
        unique case (cmd.opcode)
            OP_WRITE_CIRCUIT: begin
                if (cmd.table_select == TBL_MAIN) begin
                    if (cmd.entry_index < eff_count(main_cnt_reg)) begin
                        main_mask_tbl[cmd.entry_index][cmd.word_select*64 +: 64] = cmd.first_word;
                        main_res_tbl[cmd.entry_index][cmd.word_select*64 +: 64] = cmd.second_word;
                    end
                end else if (cmd.entry_index < eff_count(prep_count_reg)) begin
                    prep_mask_tbl[cmd.entry_index][cmd.word_select*64 +: 64] = cmd.first_word;
                    prep_res_tbl[cmd.entry_index][cmd.word_select*64 +: 64] = cmd.second_word;
                end
            end
            OP_SET_BIT:   status_now[cmd.bit_index] = 1'b1;
            OP_CLEAR_BIT: status_now[cmd.bit_index] = 1'b0;
            OP_CORRECT_WORD: begin
                status_now[cmd.word_select*64 +: 64] =
                    cmd.first_word | (prior[cmd.word_select*64 +: 64] & cmd.second_word);
            end
            OP_RECALCULATE: begin
                // prepare pass against status, folded into the working copy
                for (e = 0; e < eff_count(prep_count_reg); e++)
                    if ((prep_mask_tbl[e] & ~status_now) == '0)
                        acc |= prep_res_tbl[e];
                work = status_now | acc;
                acc  = '0;
                // main pass against the working copy
                for (e = 0; e < eff_count(main_cnt_reg); e++)
                    if ((main_mask_tbl[e] & ~work) == '0)
                        acc |= main_res_tbl[e];
                for (w = 0; w < 4; w++) begin
                    beats[w].result_word = acc[w*64 +: 64];
                    beats[w].word_number = 2'(w);
                    beats[w].last_word   = (w == 3);
                    beats[w].was_pending = recalc_flag;
                end
                recalc_flag = 1'b0;
                n = 4;
            end
            default: ;
        endcase
        if (status_now != prior)
            recalc_flag = 1'b1;
        return n;
    endfunction

    function automatic cla_in_t cmd_of(input logic [2:0] op, input logic tbl,
                                       input logic [7:0] entry, input logic [1:0] wsel,
                                       input logic [7:0] bidx, input logic [63:0] first,
                                       input logic [63:0] second);
        cla_in_t cmd;
        cmd.opcode       = op;
        cmd.table_select = tbl;
        cmd.entry_index  = entry;
        cmd.word_select  = wsel;
        cmd.bit_index    = bidx;
        cmd.first_word   = first;
        cmd.second_word  = second;
        return cmd;
    endfunction

    // mostly empty or single-bit words, so that masks often fall inside the status
    function automatic logic [63:0] sparse_word();
        unique case ($urandom_range(0, 9))
            0, 1, 2, 3: return '0;
            4, 5, 6:    return 64'd1 << $urandom_range(0, 63);
            7:          return 64'd1 << $urandom_range(0, 7);
            8:          return {$urandom, $urandom} & {$urandom, $urandom} & {$urandom, $urandom};
            default:    return {$urandom, $urandom};
        endcase
    endfunction

    function automatic cla_in_t random_command();
        cla_in_t cmd;
        int      roll;
        int      span;
        // unused fields carry noise
        cmd.opcode       = 3'($urandom);
        cmd.table_select = 1'($urandom);
        cmd.entry_index  = 8'($urandom);
        cmd.word_select  = 2'($urandom);
        cmd.bit_index    = 8'($urandom);
        cmd.first_word   = {$urandom, $urandom};
        cmd.second_word  = {$urandom, $urandom};
        roll = $urandom_range(0, 99);
        if (roll < 35) begin
            cmd.opcode = OP_WRITE_CIRCUIT;
            span = eff_count(cmd.table_select == TBL_MAIN ? main_cnt_reg : prep_count_reg);
            if (span > 0 && $urandom_range(0, 99) < 88)
                cmd.entry_index = 8'($urandom_range(0, span - 1));
            cmd.first_word  = sparse_word();
            cmd.second_word = sparse_word() | sparse_word();
        end else if (roll < 67) begin
            cmd.opcode = (roll < 55) ? OP_SET_BIT : OP_CLEAR_BIT;
            // half the time stay in the low byte of a word, where masks gather
            if ($urandom_range(0, 1))
                cmd.bit_index[5:3] = 3'b000;
        end else if (roll < 77) begin
            cmd.opcode     = OP_CORRECT_WORD;
            cmd.first_word = sparse_word();
            if ($urandom_range(0, 1))
                cmd.second_word = ALL_ONES;
        end else if (roll < 95) begin
            cmd.opcode = OP_RECALCULATE;
        end else begin
            cmd.opcode = 3'(OP_RESERVED_5 + $urandom_range(0, 2));
        end
        return cmd;
    endfunction

    // both count registers, one per cycle, while no command is in flight
    task automatic write_counts(input logic [COUNT_W-1:0] prep, input logic [COUNT_W-1:0] main);
        cfg_we    <= 1'b1;
        cfg_index <= CFG_PREPARE_COUNT;
        cfg_wdata <= prep;
        @(posedge aclk);
        cfg_index <= CFG_MAIN_COUNT;
        cfg_wdata <= main;
        @(posedge aclk);
        cfg_we <= 1'b0;
        prep_count_reg = prep;
        main_cnt_reg   = main;
    endtask

    // offers one command beat, then predicts it once it has been taken
    task automatic send_command(input cla_in_t cmd, input logic typed,
                                input logic [255:0] typed_result, input logic typed_pending);
        cla_out_t beats [4];
        int       n;
        int       w;
        while (!steady_flow && $urandom_range(0, 99) < IDLE_PCT) begin
            s_valid <= 1'b0;
            @(posedge aclk);
        end
        s_valid <= 1'b1;
        s_data  <= cmd;
        do @(posedge aclk); while (!s_ready);
        n = predict_command(cmd, beats);
        for (w = 0; w < n; w++) begin
            if (typed) begin
                beats[w].result_word = typed_result[w*64 +: 64];
                beats[w].was_pending = typed_pending;
            end
            awaited_words.push_back(beats[w]);
        end
    endtask

    // result side: check each beat, then decide ready for the next cycle
    initial begin
        cla_out_t want;
        int       hold_left;
        logic     stall_done;
        hold_left  = 0;
        stall_done = 1'b0;
        m_ready <= 1'b0;
        forever begin
            @(posedge aclk);
            if (m_valid && m_ready) begin
                if (awaited_words.size() == 0) begin
                    $error("result beat with nothing expected: %h", m_data);
                    error_count++;
                end else begin
                    want = awaited_words.pop_front();
                    if (m_data.result_word !== want.result_word) begin
                        $error("result_word: expected %h, got %h",
                               want.result_word, m_data.result_word);
                        error_count++;
                    end
                    if (m_data.word_number !== want.word_number) begin
                        $error("word_number: expected %0d, got %0d",
                               want.word_number, m_data.word_number);
                        error_count++;
                    end
                    if (m_data.last_word !== want.last_word) begin
                        $error("last_word: expected %0b, got %0b",
                               want.last_word, m_data.last_word);
                        error_count++;
                    end
                    if (m_data.was_pending !== want.was_pending) begin
                        $error("was_pending: expected %0b, got %0b",
                               want.was_pending, m_data.was_pending);
                        error_count++;
                    end
                end
            end
            // one long hold-off so the block backs up into its input
            if (stall_request && !stall_done) begin
                hold_left  = HOLD_CYCLES;
                stall_done = 1'b1;
            end
            if (hold_left > 0) begin
                hold_left--;
                m_ready <= 1'b0;
            end else begin
                m_ready <= steady_flow || ($urandom_range(0, 99) >= IDLE_PCT);
            end
        end
    end

    // watchdog on cycles with no beat moving on either channel
    initial begin
        int quiet;
        quiet = 0;
        while (quiet < WATCHDOG_LIMIT) begin
            @(posedge aclk);
            if ((s_valid && s_ready) || (m_valid && m_ready))
                quiet = 0;
            else
                quiet++;
        end
        $display("contact_logic_array_evaluator_test failed");
        $finish;
    end

    // stimulus
    initial begin
        directed_row_t row;
        int            p;
        int            i;
        aresetn   <= 1'b0;
        s_valid   <= 1'b0;
        s_data    <= '0;
        cfg_we    <= 1'b0;
        cfg_index <= CFG_PREPARE_COUNT;
        cfg_wdata <= '0;

        // directed table, run with two prepare and two main circuits
        // all-zero tables give an all-zero result, nothing pending yet
        directed_rows.push_back('{cmd_of(OP_RECALCULATE, TBL_PREPARE, 8'd0, 2'd0, 8'd0,
                                         64'd0, 64'd0), 1'b1, 256'd0, 1'b0});
        directed_rows.push_back('{cmd_of(OP_SET_BIT, TBL_PREPARE, 8'd0, 2'd0, 8'd0,
                                         64'd0, 64'd0), 1'b0, 256'd0, 1'b0});
        directed_rows.push_back('{cmd_of(OP_SET_BIT, TBL_PREPARE, 8'd0, 2'd0, 8'd255,
                                         64'd0, 64'd0), 1'b0, 256'd0, 1'b0});
        directed_rows.push_back('{cmd_of(OP_RECALCULATE, TBL_PREPARE, 8'd0, 2'd0, 8'd0,
                                         64'd0, 64'd0), 1'b1, 256'd0, 1'b1});
        directed_rows.push_back('{cmd_of(OP_RECALCULATE, TBL_PREPARE, 8'd0, 2'd0, 8'd0,
                                         64'd0, 64'd0), 1'b1, 256'd0, 1'b0});
        // setting a bit already set leaves the flag clear
        directed_rows.push_back('{cmd_of(OP_SET_BIT, TBL_PREPARE, 8'd0, 2'd0, 8'd0,
                                         64'd0, 64'd0), 1'b0, 256'd0, 1'b0});
        directed_rows.push_back('{cmd_of(OP_RECALCULATE, TBL_PREPARE, 8'd0, 2'd0, 8'd0,
                                         64'd0, 64'd0), 1'b1, 256'd0, 1'b0});
        // prepare circuit feeds bit 1 into the working copy, main circuit keys on it
        directed_rows.push_back('{cmd_of(OP_WRITE_CIRCUIT, TBL_PREPARE, 8'd0, 2'd0, 8'd0,
                                         64'd1, 64'd2), 1'b0, 256'd0, 1'b0});
        directed_rows.push_back('{cmd_of(OP_WRITE_CIRCUIT, TBL_MAIN, 8'd1, 2'd0, 8'd0,
                                         64'd2, 64'd0), 1'b0, 256'd0, 1'b0});
        directed_rows.push_back('{cmd_of(OP_WRITE_CIRCUIT, TBL_MAIN, 8'd1, 2'd3, 8'd0,
                                         64'd0, ALL_ONES), 1'b0, 256'd0, 1'b0});
        // writes past the table count are dropped
        directed_rows.push_back('{cmd_of(OP_WRITE_CIRCUIT, TBL_PREPARE, 8'd2, 2'd1, 8'd0,
                                         64'd0, ALL_ONES), 1'b0, 256'd0, 1'b0});
        directed_rows.push_back('{cmd_of(OP_WRITE_CIRCUIT, TBL_MAIN, 8'd255, 2'd2, 8'd0,
                                         64'd0, ALL_ONES), 1'b0, 256'd0, 1'b0});
        // circuit writes do not raise the flag
        directed_rows.push_back('{cmd_of(OP_RECALCULATE, TBL_PREPARE, 8'd0, 2'd0, 8'd0,
                                         64'd0, 64'd0), 1'b1, {ALL_ONES, 192'd0}, 1'b0});
        directed_rows.push_back('{cmd_of(OP_CLEAR_BIT, TBL_PREPARE, 8'd0, 2'd0, 8'd0,
                                         64'd0, 64'd0), 1'b0, 256'd0, 1'b0});
        directed_rows.push_back('{cmd_of(OP_RECALCULATE, TBL_PREPARE, 8'd0, 2'd0, 8'd0,
                                         64'd0, 64'd0), 1'b0, 256'd0, 1'b0});
        // corrections: force a word on, an unchanged one, and a clear of a zero word
        directed_rows.push_back('{cmd_of(OP_CORRECT_WORD, TBL_PREPARE, 8'd0, 2'd2, 8'd0,
                                         ALL_ONES, 64'd0), 1'b0, 256'd0, 1'b0});
        directed_rows.push_back('{cmd_of(OP_CORRECT_WORD, TBL_PREPARE, 8'd0, 2'd2, 8'd0,
                                         64'd0, ALL_ONES), 1'b0, 256'd0, 1'b0});
        directed_rows.push_back('{cmd_of(OP_CORRECT_WORD, TBL_PREPARE, 8'd0, 2'd0, 8'd0,
                                         64'd0, 64'd0), 1'b0, 256'd0, 1'b0});
        directed_rows.push_back('{cmd_of(OP_RECALCULATE, TBL_PREPARE, 8'd0, 2'd0, 8'd0,
                                         64'd0, 64'd0), 1'b0, 256'd0, 1'b0});
        // word boundaries, with unused fields at their top values
        directed_rows.push_back('{cmd_of(OP_SET_BIT, TBL_MAIN, 8'd255, 2'd3, 8'd127,
                                         ALL_ONES, ALL_ONES), 1'b0, 256'd0, 1'b0});
        directed_rows.push_back('{cmd_of(OP_CLEAR_BIT, TBL_MAIN, 8'd255, 2'd3, 8'd128,
                                         ALL_ONES, ALL_ONES), 1'b0, 256'd0, 1'b0});
        // opcodes with no meaning change nothing
        directed_rows.push_back('{cmd_of(OP_RESERVED_5, TBL_MAIN, 8'd0, 2'd0, 8'd0,
                                         ALL_ONES, ALL_ONES), 1'b0, 256'd0, 1'b0});
        directed_rows.push_back('{cmd_of(OP_RESERVED_6, TBL_MAIN, 8'd0, 2'd3, 8'd255,
                                         ALL_ONES, 64'd0), 1'b0, 256'd0, 1'b0});
        directed_rows.push_back('{cmd_of(OP_RESERVED_7, TBL_PREPARE, 8'd255, 2'd3, 8'd255,
                                         ALL_ONES, ALL_ONES), 1'b0, 256'd0, 1'b0});
        directed_rows.push_back('{cmd_of(OP_RECALCULATE, TBL_MAIN, 8'd255, 2'd3, 8'd255,
                                         ALL_ONES, ALL_ONES), 1'b0, 256'd0, 1'b0});

        repeat (11) @(posedge aclk);
        aresetn <= 1'b1;
        write_counts(9'd2, 9'd2);

        foreach (directed_rows[i]) begin
            row = directed_rows[i];
            send_command(row.cmd, row.typed, row.typed_result, row.typed_pending);
        end

        // random phases, each behind a count change made while idle
        for (p = 0; p < PHASES; p++) begin
            s_valid <= 1'b0;
            while (awaited_words.size() != 0)
                @(posedge aclk);
            repeat (SETTLE_CYCLES) @(posedge aclk);
            write_counts(COUNT_W'(PHASE_PREP[p]), COUNT_W'(PHASE_MAIN[p]));
            steady_flow = (p == STEADY_PHASE);
            if (p == STALL_PHASE)
                stall_request = 1'b1;
            for (i = 0; i < PHASE_ITEMS; i++)
                send_command(random_command(), 1'b0, 256'd0, 1'b0);
        end

        // drain, then allow for any stray beat
        s_valid <= 1'b0;
        while (awaited_words.size() != 0)
            @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);
        if (error_count == 0)
            $display("contact_logic_array_evaluator_test passed");
        else
            $display("contact_logic_array_evaluator_test failed");
        $finish;
    end

endmodule
